[hw/rtl/ssw_pkg.sv]
`default_nettype none

package ssw_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_SENT  = 2'd2
  } kind_t;

  // characters the scanner reacts to
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // most result words one character can release
  localparam int unsigned MAX_RES = 3;

  // scanner state carried from one decision to the next
  typedef struct packed {
    logic        skip;
    logic        drun;
    logic [15:0] cnt;
    logic [7:0]  p0;
    logic [7:0]  p1;
  } st_t;

  // one result word
  typedef struct packed {
    logic [7:0]  ch;
    kind_t       kind;
    logic [15:0] cnt;
  } res_t;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_BANG) || (c == CH_QUEST) ||
           (c == CH_COMMA) || (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ssw_decide.sv]
`default_nettype none

// Decision for one character with up to two characters of look-ahead.
module ssw_decide (
  input  wire logic         en,
  input  wire logic [7:0]   c,
  input  wire logic         has1,
  input  wire logic [7:0]   n1,
  input  wire logic         has2,
  input  wire logic [7:0]   n2,
  input  wire ssw_pkg::st_t st_i,
  output ssw_pkg::st_t      st_o,
  output logic              res_v,
  output ssw_pkg::res_t     res
);

  logic [15:0] cnt_inc;

  // saturating sentence count
  assign cnt_inc = (st_i.cnt == ssw_pkg::CNT_MAX) ? st_i.cnt : st_i.cnt + 16'd1;

  always_comb begin
    st_o     = st_i;
    res_v    = 1'b0;
    res.ch   = 8'd0;
    res.kind = ssw_pkg::KIND_CHAR;
    res.cnt  = st_i.cnt;
    if (en) begin
      if (st_i.skip) begin
        st_o.skip = 1'b0;
      end else if (c == ssw_pkg::CH_DOT) begin
        if (!has1) begin
          st_o.cnt  = cnt_inc;
          st_o.drun = 1'b0;
          res_v     = 1'b1;
          res.kind  = ssw_pkg::KIND_SENT;
          res.cnt   = cnt_inc;
        end else if (n1 == ssw_pkg::CH_SPACE) begin
          // single capital after a space: initial, not a sentence end
          if (!(ssw_pkg::is_up(st_i.p0) && st_i.p1 == ssw_pkg::CH_SPACE) &&
              has2 && ssw_pkg::is_up(n2)) begin
            st_o.cnt  = cnt_inc;
            st_o.drun = 1'b0;
            res_v     = 1'b1;
            res.kind  = ssw_pkg::KIND_SENT;
            res.cnt   = cnt_inc;
          end else begin
            res_v  = 1'b1;
            res.ch = ssw_pkg::CH_DOT;
          end
          st_o.skip = 1'b1;
        end else begin
          res_v     = 1'b1;
          res.ch    = ssw_pkg::CH_DOT;
          st_o.drun = 1'b0;
        end
      end else if (c == ssw_pkg::CH_QUOTE) begin
        // quotes are dropped
      end else if (ssw_pkg::is_delim(c)) begin
        if (!st_i.drun) begin
          res_v     = 1'b1;
          res.kind  = ssw_pkg::KIND_BREAK;
          st_o.drun = 1'b1;
        end
      end else begin
        res_v     = 1'b1;
        res.ch    = ssw_pkg::is_up(c) ? c + ssw_pkg::CASE_OFS : c;
        st_o.drun = 1'b0;
      end
      st_o.p1 = st_i.p0;
      st_o.p0 = c;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ssw_core.sv]
`default_nettype none

// Look-ahead window, scanner state and the three decision slots.
module ssw_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [7:0]          ch,
  input  wire logic                le,
  output ssw_pkg::res_t [2:0]      res,
  output logic          [1:0]      res_n
);

  ssw_pkg::st_t st_r, st_nxt;
  logic [7:0]   pc0_r, pc0_nxt, pc1_r, pc1_nxt;
  logic         pv0_r, pv0_nxt, pv1_r, pv1_nxt;

  logic [7:0]   lst [3];
  logic [1:0]   m;
  logic [2:0]   en;
  logic [2:0]   has1;
  logic [2:0]   has2;
  ssw_pkg::st_t st_c [4];
  logic [2:0]   rv;
  ssw_pkg::res_t rr [3];

  // character list: pending characters then the new one
  always_comb begin
    lst[0] = ch;
    lst[1] = 8'd0;
    lst[2] = 8'd0;
    m      = 2'd1;
    if (pv0_r) begin
      lst[0] = pc0_r;
      if (pv1_r) begin
        lst[1] = pc1_r;
        lst[2] = ch;
        m      = 2'd3;
      end else begin
        lst[1] = ch;
        m      = 2'd2;
      end
    end
    for (int k = 0; k < 3; k++) begin
      has1[k] = (k + 1) < int'(m);
      has2[k] = (k + 2) < int'(m);
      if (le) begin
        en[k] = k < int'(m);
      end else begin
        en[k] = (k == 0) && (m == 2'd3);
      end
    end
  end

  assign st_c[0] = st_r;

  for (genvar k = 0; k < 3; k++) begin : g_slot
    logic [7:0] n1_k, n2_k;
    assign n1_k = (k + 1 < 3) ? lst[(k + 1) % 3] : 8'd0;
    assign n2_k = (k + 2 < 3) ? lst[(k + 2) % 3] : 8'd0;
    ssw_decide u_dec (
      .en   (en[k]),
      .c    (lst[k]),
      .has1 (has1[k]),
      .n1   (n1_k),
      .has2 (has2[k]),
      .n2   (n2_k),
      .st_i (st_c[k]),
      .st_o (st_c[k + 1]),
      .res_v(rv[k]),
      .res  (rr[k])
    );
  end

  // pack emitted words to the front, in order
  always_comb begin
    logic [1:0] pos;
    pos = 2'd0;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      if (rv[k]) begin
        res[pos] = rr[k];
        pos      = pos + 2'd1;
      end
    end
    res_n = pos;
  end

  // next state: window shift, or line-end flush
  always_comb begin
    st_nxt  = st_r;
    pc0_nxt = pc0_r;
    pc1_nxt = pc1_r;
    pv0_nxt = pv0_r;
    pv1_nxt = pv1_r;
    if (go) begin
      st_nxt = st_c[3];
      if (le) begin
        pv0_nxt     = 1'b0;
        pv1_nxt     = 1'b0;
        st_nxt.p0   = 8'd0;
        st_nxt.p1   = 8'd0;
        st_nxt.skip = 1'b0;
      end else if (pv0_r && pv1_r) begin
        pc0_nxt = pc1_r;
        pc1_nxt = ch;
      end else if (pv0_r) begin
        pc1_nxt = ch;
        pv1_nxt = 1'b1;
      end else begin
        pc0_nxt = ch;
        pv0_nxt = 1'b1;
        pv1_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      pv0_r <= 1'b0;
      pv1_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      pv0_r <= pv0_nxt;
      pv1_r <= pv1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc0_r <= pc0_nxt;
    pc1_r <= pc1_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ssw_outbuf.sv]
`default_nettype none

// Result buffer: holds the words of one character and hands them out one by one.
module ssw_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ld,
  input  wire ssw_pkg::res_t [2:0] ld_res,
  input  wire logic [1:0]          ld_n,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_char,
  output logic [1:0]               out_kind,
  output logic [15:0]              out_sentences_seen,
  output logic                     out_last
);

  ssw_pkg::res_t [2:0] slot_r, slot_nxt;
  logic [1:0]          n_r, n_nxt;
  logic [1:0]          rd_r, rd_nxt;
  logic                take;

  assign out_valid          = n_r != 2'd0;
  assign out_last           = rd_r == n_r - 2'd1;
  assign out_char           = slot_r[rd_r].ch;
  assign out_kind           = slot_r[rd_r].kind;
  assign out_sentences_seen = slot_r[rd_r].cnt;

  assign take = out_valid && out_ready;
  assign free = !out_valid || (take && out_last);

  always_comb begin
    slot_nxt = slot_r;
    n_nxt    = n_r;
    rd_nxt   = rd_r;
    if (ld) begin
      slot_nxt = ld_res;
      n_nxt    = ld_n;
      rd_nxt   = 2'd0;
    end else if (take) begin
      if (out_last) begin
        n_nxt  = 2'd0;
        rd_nxt = 2'd0;
      end else begin
        rd_nxt = rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= 2'd0;
      rd_r <= 2'd0;
    end else begin
      n_r  <= n_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/sentence_split_word_tokenizer_top.sv]
`default_nettype none

// Sentence-splitting word tokenizer. One text byte per input word, with
// in_line_end on the last byte of a line; out words are lowercased token
// bytes, token breaks and sentence breaks, each carrying the running
// sentence count. Decisions need two bytes of look-ahead, so a byte's words
// come out when later bytes arrive, and a line end flushes the window.
// Rate: one input word per cycle while each byte releases at most one result
// word and the output is not stalled; a byte that releases two or three (only
// possible at a line end) holds the input until the result buffer has drained,
// one word per cycle while out_ready is high. From input accept, the first
// result word passes through the input register, then the result buffer.
module sentence_split_word_tokenizer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_sentences_seen,
  output logic             out_last
);

  logic                s1_v_r, s1_v_nxt;
  logic [7:0]          s1_ch_r;
  logic                s1_le_r;
  logic                free;
  logic                go;
  logic                in_take;
  ssw_pkg::res_t [2:0] res;
  logic [1:0]          res_n;

  // input register advances into the result buffer when it can take a word set
  assign go       = s1_v_r && free;
  assign in_ready = !s1_v_r || free;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_take) begin
      s1_v_nxt = 1'b1;
    end else if (go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r <= in_ch;
      s1_le_r <= in_line_end;
    end
  end

  ssw_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .ch   (s1_ch_r),
    .le   (s1_le_r),
    .res  (res),
    .res_n(res_n)
  );

  ssw_outbuf u_obuf (
    .clk               (clk),
    .rst_n             (rst_n),
    .ld                (go),
    .ld_res            (res),
    .ld_n              (res_n),
    .free              (free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_kind          (out_kind),
    .out_sentences_seen(out_sentences_seen),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/ssw_checker.sv]
`default_nettype none

module ssw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_char,
  input wire logic [1:0]  out_kind,
  input wire logic [15:0] out_sentences_seen,
  input wire logic        out_last
);

  // breaks carry no character
  a_break_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != ssw_pkg::KIND_CHAR |-> out_char == 8'd0)
    else $error("break word with nonzero character");

  // a sentence break always follows at least one counted sentence
  a_sent_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ssw_pkg::KIND_SENT |-> out_sentences_seen != 16'd0)
    else $error("sentence break with zero count");

  // count moves only on a sentence break
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=>
      !out_valid || out_kind == ssw_pkg::KIND_SENT ||
      out_sentences_seen == $past(out_sentences_seen))
    else $error("sentence count changed without a sentence break");

  // stalled word holds
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_char) && $stable(out_kind) &&
      $stable(out_sentences_seen) && $stable(out_last))
    else $error("result word changed while stalled");

endmodule

bind sentence_split_word_tokenizer_top ssw_checker u_ssw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_char          (out_char),
  .out_kind          (out_kind),
  .out_sentences_seen(out_sentences_seen),
  .out_last          (out_last)
);

`default_nettype wire

[sim/sentence_split_word_tokenizer_top_tb.sv]
module sentence_split_word_tokenizer_top_tb;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LOW_A  = ssw_pkg::CH_UP_A + ssw_pkg::CASE_OFS;
  // everything that opens or extends a token break
  localparam logic [5:0][7:0] SEP_SET = {ssw_pkg::CH_SPACE, ssw_pkg::CH_BANG,
                                         ssw_pkg::CH_QUEST, ssw_pkg::CH_COMMA,
                                         ssw_pkg::CH_LPAR, ssw_pkg::CH_RPAR};
  localparam int HOLD_CYCLES = 300;

  // one result word as it appears on the out_ ports
  typedef struct packed {
    logic [7:0]  ch;
    logic [1:0]  kind;
    logic [15:0] cnt;
    logic        last;
  } word_t;

  // Tracks tokenizer state and holds the words each accepted char releases.
  class tokenizer_scoreboard;
    logic [7:0]  prev0, prev1;   // last two decided bytes, zero when absent
    logic [8:0]  pend0, pend1;   // look-ahead window, bit 8 = occupied
    bit          skip_next;
    bit          in_sep_run;
    logic [15:0] sent_cnt;
    word_t       step_words[$];
    word_t       expected_words[$];
    int          errors;

    function new();
      prev0 = '0;
      prev1 = '0;
      pend0 = '0;
      pend1 = '0;
      skip_next = 1'b0;
      in_sep_run = 1'b0;
      sent_cnt = '0;
      errors = 0;
    endfunction

    function bit is_capital(logic [7:0] c);
      return (c >= ssw_pkg::CH_UP_A) && (c <= ssw_pkg::CH_UP_Z);
    endfunction

    function bit is_separator(logic [7:0] c);
      for (int i = 0; i < 6; i++)
        if (c == SEP_SET[i]) return 1'b1;
      return 1'b0;
    endfunction

    function void push_word(logic [7:0] c, logic [1:0] k);
      word_t w;
      w.ch = c;
      w.kind = k;
      w.cnt = sent_cnt;
      w.last = 1'b0;
      step_words.push_back(w);
    endfunction

    function void end_sentence();
      if (sent_cnt != ssw_pkg::CNT_MAX) sent_cnt++;
      in_sep_run = 1'b0;
      push_word(8'h00, ssw_pkg::KIND_SENT);
    endfunction

    // decide one byte given up to two bytes of look-ahead
    function void decide_byte(logic [7:0] c, bit has1, logic [7:0] n1,
                              bit has2, logic [7:0] n2);
      if (skip_next) begin
        skip_next = 1'b0;
      end else if (c == ssw_pkg::CH_DOT) begin
        if (!has1) begin
          end_sentence();
        end else if (n1 == ssw_pkg::CH_SPACE) begin
          // initial like "J." keeps its dot
          if (is_capital(prev0) && prev1 == ssw_pkg::CH_SPACE)
            push_word(ssw_pkg::CH_DOT, ssw_pkg::KIND_CHAR);
          else if (has2 && is_capital(n2)) end_sentence();
          else push_word(ssw_pkg::CH_DOT, ssw_pkg::KIND_CHAR);
          skip_next = 1'b1;
        end else begin
          push_word(ssw_pkg::CH_DOT, ssw_pkg::KIND_CHAR);
          in_sep_run = 1'b0;
        end
      end else if (c == ssw_pkg::CH_QUOTE) begin
        // quotes vanish
      end else if (is_separator(c)) begin
        if (!in_sep_run) begin
          push_word(8'h00, ssw_pkg::KIND_BREAK);
          in_sep_run = 1'b1;
        end
      end else begin
        push_word(is_capital(c) ? c + ssw_pkg::CASE_OFS : c, ssw_pkg::KIND_CHAR);
        in_sep_run = 1'b0;
      end
      prev1 = prev0;
      prev0 = c;
    endfunction

    // accepted input char: queue the words it releases
    function void note_char(logic [7:0] c, bit le);
      logic [7:0] seq [3];
      int m;
      word_t w;
      step_words.delete();
      m = 0;
      if (!le) begin
        if (pend0[8] && pend1[8]) begin
          decide_byte(pend0[7:0], 1'b1, pend1[7:0], 1'b1, c);
          pend0 = pend1;
          pend1 = {1'b1, c};
        end else if (pend0[8]) begin
          pend1 = {1'b1, c};
        end else begin
          pend0 = {1'b1, c};
          pend1 = '0;
        end
      end else begin
        // line end flushes the window
        if (pend0[8]) begin
          seq[m] = pend0[7:0];
          m++;
          if (pend1[8]) begin
            seq[m] = pend1[7:0];
            m++;
          end
        end
        seq[m] = c;
        m++;
        for (int k = 0; k < m; k++)
          decide_byte(seq[k], k + 1 < m, (k + 1 < m) ? seq[k + 1] : 8'h00,
                      k + 2 < m, (k + 2 < m) ? seq[k + 2] : 8'h00);
        pend0 = '0;
        pend1 = '0;
        prev0 = '0;
        prev1 = '0;
        skip_next = 1'b0;
      end
      for (int i = 0; i < step_words.size(); i++) begin
        w = step_words[i];
        w.last = (i == step_words.size() - 1);
        expected_words.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] c, logic [1:0] k, logic [15:0] cnt, logic lst);
      word_t got;
      word_t want;
      got = {c, k, cnt, lst};
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word ch=%h kind=%0d cnt=%0d last=%b",
                 $time, c, k, cnt, lst);
        return;
      end
      want = expected_words.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected ch=%h kind=%0d cnt=%0d last=%b",
                 $time, want.ch, want.kind, want.cnt, want.last,
                 " got ch=%h kind=%0d cnt=%0d last=%b",
                 got.ch, got.kind, got.cnt, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_ch;
  logic        in_line_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_char;
  logic [1:0]  out_kind;
  logic [15:0] out_sentences_seen;
  logic        out_last;

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_req;

  tokenizer_scoreboard sb = new();

  sentence_split_word_tokenizer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_ch              (in_ch),
    .in_line_end        (in_line_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_char           (out_char),
    .out_kind           (out_kind),
    .out_sentences_seen (out_sentences_seen),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(8 * 600000);
    $display("sentence_split_word_tokenizer_top_tb NOT OK");
    $finish;
  end

  // result side: random stalls, plus a long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_char, out_kind, out_sentences_seen, out_last);
  end

  // text-like byte; some fully random
  function automatic logic [7:0] text_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) return 8'(CH_LOW_A + $urandom_range(25));
    if (pick < 40) return 8'(ssw_pkg::CH_UP_A + $urandom_range(25));
    if (pick < 55) return ssw_pkg::CH_SPACE;
    if (pick < 63) return ssw_pkg::CH_DOT;
    if (pick < 73) return SEP_SET[$urandom_range(5)];
    if (pick < 78) return ssw_pkg::CH_QUOTE;
    if (pick < 80) return CH_DOLLAR;
    return 8'($urandom_range(255));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic le);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_line_end <= le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_char(c, le);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // lines built from sentence-like fragments and noise
  task automatic send_random_lines(input int count);
    logic [7:0] line_q[$];
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      line_q.delete();
      repeat ($urandom_range(6, 1)) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          repeat ($urandom_range(4, 1))
            line_q.push_back(8'(CH_LOW_A + $urandom_range(25)));
        end else if (pick < 45) begin
          // sentence end inside the line
          line_q.push_back(ssw_pkg::CH_DOT);
          line_q.push_back(ssw_pkg::CH_SPACE);
          line_q.push_back(8'(ssw_pkg::CH_UP_A + $urandom_range(25)));
        end else if (pick < 55) begin
          // initial such as " J. "
          line_q.push_back(ssw_pkg::CH_SPACE);
          line_q.push_back(8'(ssw_pkg::CH_UP_A + $urandom_range(25)));
          line_q.push_back(ssw_pkg::CH_DOT);
          line_q.push_back(ssw_pkg::CH_SPACE);
        end else if (pick < 70) begin
          repeat ($urandom_range(3, 1))
            line_q.push_back(($urandom_range(4) == 0) ? ssw_pkg::CH_QUOTE
                                                       : SEP_SET[$urandom_range(5)]);
        end else begin
          line_q.push_back(text_byte());
        end
      end
      for (int i = 0; i < line_q.size(); i++)
        send_char(line_q[i], i == line_q.size() - 1);
      sent += line_q.size();
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = 8'h00;
    in_line_end = 1'b0;
    hold_req = 1'b0;
    tx_idle_pct = 31;
    rx_idle_pct = 85;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: initials, sentence ends, separators, quotes, odd bytes
    send_text("I J. a. Ok.");
    send_text(".y a. b!?,(\"$)");
    send_char(8'h40, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_text(".");
    send_random_lines(130);
    wait_drained();

    tx_idle_pct = 85;
    rx_idle_pct = 31;
    send_random_lines(150);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_lines(30);
    // long output stall while input keeps coming
    hold_req = 1'b1;
    send_random_lines(50);
    send_random_lines(60);
    wait_drained();

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("sentence_split_word_tokenizer_top_tb OK");
    end else begin
      $display("sentence_split_word_tokenizer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/ssw_pkg.sv
hw/rtl/ssw_decide.sv
hw/rtl/ssw_core.sv
hw/rtl/ssw_outbuf.sv
hw/rtl/sentence_split_word_tokenizer_top.sv
hw/rtl/ssw_checker.sv
sim/sentence_split_word_tokenizer_top_tb.sv
